/* src/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock, masked while reset is low.
`define GRE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same check, also active during reset.
`define GRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/gre_pkg.sv */
package gre_pkg;

  localparam int unsigned MAX_DIM_DEF = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [47:0] SUM_MAX     = 48'hFFFF_FFFF_FFFF;
  localparam logic [4:0]  COUNT_MAX   = 5'd31;
  localparam logic [5:0]  EXP_STEPS   = 6'd48;
  localparam logic [15:0] AMP_RESET   = 16'd256;
  localparam logic [4:0]  DIMC_RESET  = 5'd1;

  typedef enum logic [1:0] {
    OP_DATA   = 2'd0,
    OP_SINGLE = 2'd1,
    OP_SHARED = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_ZERO_LS  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE = 2'd0,
    REG_DIM_COUNT = 2'd1
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_LSQ, S_DST, S_DIV, S_SQ, S_MW, S_ACC, S_EXP1, S_EXP2, S_EXP3, S_RES
  } state_e;

  typedef struct packed {
    logic        start;
    logic [32:0] numer;
    logic [31:0] denom;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  // exp(-k/4) in Q1.16, k = 0..48
  function automatic logic [16:0] exp_lut(input logic [5:0] k);
    logic [16:0] v;
    case (k)
      6'd0:  v = 17'd65536; 6'd1:  v = 17'd51039; 6'd2:  v = 17'd39750;
      6'd3:  v = 17'd30957; 6'd4:  v = 17'd24109; 6'd5:  v = 17'd18776;
      6'd6:  v = 17'd14623; 6'd7:  v = 17'd11388; 6'd8:  v = 17'd8869;
      6'd9:  v = 17'd6907;  6'd10: v = 17'd5380;  6'd11: v = 17'd4190;
      6'd12: v = 17'd3263;  6'd13: v = 17'd2541;  6'd14: v = 17'd1979;
      6'd15: v = 17'd1541;  6'd16: v = 17'd1200;  6'd17: v = 17'd935;
      6'd18: v = 17'd728;   6'd19: v = 17'd567;   6'd20: v = 17'd442;
      6'd21: v = 17'd344;   6'd22: v = 17'd268;   6'd23: v = 17'd209;
      6'd24: v = 17'd162;   6'd25: v = 17'd127;   6'd26: v = 17'd99;
      6'd27: v = 17'd77;    6'd28: v = 17'd60;    6'd29: v = 17'd47;
      6'd30: v = 17'd36;    6'd31: v = 17'd28;    6'd32: v = 17'd22;
      6'd33: v = 17'd17;    6'd34: v = 17'd13;    6'd35: v = 17'd10;
      6'd36: v = 17'd8;     6'd37: v = 17'd6;     6'd38: v = 17'd5;
      6'd39: v = 17'd4;     6'd40: v = 17'd3;     6'd41: v = 17'd2;
      6'd42: v = 17'd2;     6'd43: v = 17'd1;     6'd44: v = 17'd1;
      6'd45: v = 17'd1;     6'd46: v = 17'd1;     6'd47: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

/* src/gre_in_if.sv */
interface gre_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  dim_index;
  logic signed [15:0] x_value;
  logic signed [15:0] y_value;
  logic [15:0] lengthscale;
  logic        last_element;

  modport source (output valid, opcode, dim_index, x_value, y_value, lengthscale,
                  last_element, input ready);
  modport sink (input valid, opcode, dim_index, x_value, y_value, lengthscale,
                last_element, output ready);
endinterface

/* src/gre_out_if.sv */
interface gre_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] kernel_value;
  logic [1:0]  status;
  logic        from_write;

  modport source (output valid, kernel_value, status, from_write, input ready);
  modport sink (input valid, kernel_value, status, from_write, output ready);
endinterface

/* src/gre_wdiv.sv */
// Restoring divider, one quotient bit per cycle.
module gre_wdiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gre_pkg::div_req_t req_i,
  output gre_pkg::div_rsp_t rsp_o
);

  logic [32:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [32:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (req_i.start) begin
      num_d  = req_i.numer;
      den_d  = req_i.denom;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 6'd33;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, num_q[32]} - {2'b00, den_q};
      num_d = {num_q[31:0], 1'b0};
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], num_q[32]};
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  // saturate to 32 bits
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q[32] ? 32'hFFFF_FFFF : quo_q[31:0];

endmodule

/* src/gre_wmem.sv */
// Weight store, one write and one registered read per cycle.
module gre_wmem #(
  parameter int unsigned DEPTH = gre_pkg::MAX_DIM_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* src/gaussian_rbf_kernel_eval.sv */
// Gaussian kernel with per-dimension length scales: k = amplitude * exp(-sum (x-y)^2 * w),
// w = 1/(2*l^2) in Q0.32. Per-dimension weights live in a synchronous memory read at the
// element position, a shared weight in a register. One multiplier is shared by all
// multiply steps; an accepted data word passes through square, weight multiply and
// saturating add, a last element then through the interpolated exp, the amplitude scale
// and the result load, and a lengthscale write waits on the bit-serial weight divider. A
// result waits in an output register while the next word is taken in.
`include "assert_macros.svh"

module gaussian_rbf_kernel_eval #(
  parameter int unsigned MAX_DIM = gre_pkg::MAX_DIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  gre_in_if.sink                         in_if,
  gre_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [gre_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gre_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  gre_pkg::state_e state_q, state_d;

  logic [15:0] amp_q;
  logic [4:0]  dimc_q;
  logic [31:0] shw_q, shw_d;
  logic        use_sh_q, use_sh_d;
  logic [47:0] sum_q, sum_d;
  logic [4:0]  cnt_q, cnt_d;

  logic [1:0]  op_q;
  logic [3:0]  di_q;
  logic [15:0] ad_q;
  logic [15:0] ls_q;
  logic        last_q;
  logic [31:0] w_q, w_d;
  logic [16:0] ea_q, ea_d;

  logic [15:0] rkv_q, rkv_d;
  logic [1:0]  rstat_q, rstat_d;
  logic        rfw_q, rfw_d;

  logic        ovalid_q, ovalid_d;
  logic [15:0] okv_q;
  logic [1:0]  ostat_q;
  logic        ofw_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_q;

  logic        accept, out_free, load_out;
  logic signed [16:0] diff;
  logic [16:0] diff_abs;

  gre_pkg::div_req_t div_req;
  gre_pkg::div_rsp_t div_rsp;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_rdata;
  logic [6:0]    di_ext, cnt_ext;

  logic [48:0] sum_add;
  logic [47:0] term;
  logic        mismatch;
  logic [5:0]  eidx;
  logic [16:0] eb;
  logic [30:0] interp;
  logic [16:0] e_val;
  logic [32:0] scaled;

  assign accept   = in_if.valid && in_if.ready;
  assign out_free = !ovalid_q || out_if.ready;
  assign in_if.ready = (state_q == gre_pkg::S_IDLE);

  assign diff     = {in_if.x_value[15], in_if.x_value} - {in_if.y_value[15], in_if.y_value};
  assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);

  assign di_ext    = 7'(di_q);
  assign cnt_ext   = 7'(cnt_q);
  assign mem_waddr = di_ext[AW-1:0];
  assign mem_raddr = cnt_ext[AW-1:0];

  gre_wmem #(.DEPTH(MAX_DIM), .AW(AW)) u_wmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (div_rsp.quot),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  gre_wdiv u_wdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gre_pkg::S_IDLE: begin
        if (accept) begin
          case (in_if.opcode)
            gre_pkg::OP_DATA: state_d = gre_pkg::S_SQ;
            gre_pkg::OP_SINGLE, gre_pkg::OP_SHARED:
              state_d = (in_if.lengthscale == '0) ? gre_pkg::S_RES : gre_pkg::S_LSQ;
            default: state_d = gre_pkg::S_IDLE;
          endcase
        end
      end
      gre_pkg::S_LSQ:  state_d = gre_pkg::S_DST;
      gre_pkg::S_DST:  state_d = gre_pkg::S_DIV;
      gre_pkg::S_DIV:  if (div_rsp.done) state_d = gre_pkg::S_RES;
      gre_pkg::S_SQ:   state_d = gre_pkg::S_MW;
      gre_pkg::S_MW:   state_d = gre_pkg::S_ACC;
      gre_pkg::S_ACC: begin
        if (!last_q) begin
          state_d = gre_pkg::S_IDLE;
        end else begin
          state_d = mismatch ? gre_pkg::S_RES : gre_pkg::S_EXP1;
        end
      end
      gre_pkg::S_EXP1: state_d = gre_pkg::S_EXP2;
      gre_pkg::S_EXP2: state_d = gre_pkg::S_EXP3;
      gre_pkg::S_EXP3: state_d = gre_pkg::S_RES;
      gre_pkg::S_RES:  if (out_free) state_d = gre_pkg::S_IDLE;
      default:         state_d = gre_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    shw_d    = shw_q;
    use_sh_d = use_sh_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    w_d      = w_q;
    ea_d     = ea_q;
    rkv_d    = rkv_q;
    rstat_d  = rstat_q;
    rfw_d    = rfw_q;
    mul_a    = '0;
    mul_b    = '0;
    mem_we   = 1'b0;
    div_req  = '0;
    load_out = 1'b0;
    term     = prod_q[63:16];
    sum_add  = {1'b0, sum_q} + {1'b0, term};
    mismatch = 1'b0;
    eidx     = '0;
    eb       = '0;
    interp   = 31'(prod_q[29:0]) + 31'd8192;
    e_val    = ea_q - 17'(interp[30:14]);
    scaled   = prod_q[32:0] + 33'd32768;
    ovalid_d = ovalid_q && !out_if.ready;
    case (state_q)
      gre_pkg::S_IDLE: begin
        if (accept && in_if.lengthscale == '0 &&
            (in_if.opcode == gre_pkg::OP_SINGLE || in_if.opcode == gre_pkg::OP_SHARED)) begin
          rkv_d   = '0;
          rstat_d = gre_pkg::ST_ZERO_LS;
          rfw_d   = 1'b1;
        end
      end
      gre_pkg::S_LSQ: begin
        mul_a = 32'(ls_q);
        mul_b = 32'(ls_q);
      end
      gre_pkg::S_DST: begin
        div_req.start = 1'b1;
        div_req.numer = 33'h0_8000_0000 + 33'(prod_q[31:1]);
        div_req.denom = prod_q[31:0];
      end
      gre_pkg::S_DIV: begin
        if (div_rsp.done) begin
          if (op_q == gre_pkg::OP_SHARED) begin
            shw_d    = div_rsp.quot;
            use_sh_d = 1'b1;
          end else begin
            mem_we   = (di_ext < 7'(MAX_DIM));
            use_sh_d = 1'b0;
          end
          rkv_d   = '0;
          rstat_d = gre_pkg::ST_OK;
          rfw_d   = 1'b1;
        end
      end
      gre_pkg::S_SQ: begin
        mul_a = 32'(ad_q);
        mul_b = 32'(ad_q);
        // memory word read at accept is valid now
        if (use_sh_q) begin
          w_d = shw_q;
        end else if (cnt_ext < 7'(MAX_DIM)) begin
          w_d = mem_rdata;
        end else begin
          w_d = '0;
        end
      end
      gre_pkg::S_MW: begin
        mul_a = prod_q[31:0];
        mul_b = w_q;
      end
      gre_pkg::S_ACC: begin
        sum_d = sum_add[48] ? gre_pkg::SUM_MAX : sum_add[47:0];
        cnt_d = (cnt_q < gre_pkg::COUNT_MAX) ? cnt_q + 5'd1 : cnt_q;
        mismatch = (dimc_q == '0) || (7'(dimc_q) > 7'(MAX_DIM)) || (cnt_d != dimc_q);
        if (last_q) begin
          cnt_d = '0;
          if (mismatch) begin
            sum_d   = '0;
            rkv_d   = '0;
            rstat_d = gre_pkg::ST_MISMATCH;
            rfw_d   = 1'b0;
          end
        end
      end
      gre_pkg::S_EXP1: begin
        // past the table the interpolation collapses to zero
        if (sum_q[47:14] >= 34'(gre_pkg::EXP_STEPS)) begin
          ea_d = '0;
        end else begin
          eidx  = sum_q[19:14];
          ea_d  = gre_pkg::exp_lut(eidx);
          eb    = gre_pkg::exp_lut(eidx + 6'd1);
          mul_a = 32'(ea_d - eb);
          mul_b = 32'(sum_q[13:0]);
        end
        sum_d = '0;
      end
      gre_pkg::S_EXP2: begin
        mul_a = 32'(amp_q);
        mul_b = 32'(e_val);
      end
      gre_pkg::S_EXP3: begin
        rkv_d   = scaled[31:16];
        rstat_d = gre_pkg::ST_OK;
        rfw_d   = 1'b0;
      end
      gre_pkg::S_RES: begin
        if (out_free) begin
          load_out = 1'b1;
          ovalid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gre_pkg::S_IDLE;
      amp_q    <= gre_pkg::AMP_RESET;
      dimc_q   <= gre_pkg::DIMC_RESET;
      shw_q    <= '0;
      use_sh_q <= 1'b1;
      sum_q    <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      shw_q    <= shw_d;
      use_sh_q <= use_sh_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          gre_pkg::REG_AMPLITUDE: amp_q  <= cfg_data_i;
          gre_pkg::REG_DIM_COUNT: dimc_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= mul_a * mul_b;
    w_q     <= w_d;
    ea_q    <= ea_d;
    rkv_q   <= rkv_d;
    rstat_q <= rstat_d;
    rfw_q   <= rfw_d;
    if (accept) begin
      op_q   <= in_if.opcode;
      di_q   <= in_if.dim_index;
      ad_q   <= diff_abs[15:0];
      ls_q   <= in_if.lengthscale;
      last_q <= in_if.last_element;
    end
    if (load_out) begin
      okv_q   <= rkv_q;
      ostat_q <= rstat_q;
      ofw_q   <= rfw_q;
    end
  end

  assign out_if.valid        = ovalid_q;
  assign out_if.kernel_value = okv_q;
  assign out_if.status       = ostat_q;
  assign out_if.from_write   = ofw_q;

  `GRE_ASSERT(a_div_done_state, clk_i, rst_ni,
    div_rsp.done |-> state_q == gre_pkg::S_DIV, "divider done outside wait state")
  `GRE_ASSERT(a_data_to_square, clk_i, rst_ni,
    (accept && in_if.opcode == gre_pkg::OP_DATA) |=> state_q == gre_pkg::S_SQ,
    "data word did not enter square step")
  `GRE_ASSERT(a_ack_zero_value, clk_i, rst_ni,
    (ovalid_q && ofw_q) |-> okv_q == '0, "write ack carries a nonzero value")
  `GRE_ASSERT_ALWAYS(a_ready_only_idle, clk_i,
    in_if.ready |-> state_q == gre_pkg::S_IDLE, "input ready while busy")

endmodule

/* tb/gaussian_rbf_kernel_eval_tb.sv */
module gaussian_rbf_kernel_eval_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NDIM = 16;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam longint unsigned CYCLE_LIMIT = 600000;

  typedef struct {
    gre_pkg::opcode_e   op;
    logic [3:0]         dim;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        ls;
    logic               last;
  } word_t;

  typedef struct {
    logic [15:0]      kval;
    gre_pkg::status_e st;
    logic             fw;
  } kres_t;

  typedef struct {
    word_t w;
    bit    typed;
    kres_t r;
  } drow_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [gre_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [gre_pkg::CFG_DATA_W-1:0] cfg_data_i;

  gre_in_if  in_bus ();
  gre_out_if out_bus ();

  gaussian_rbf_kernel_eval dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_bus),
    .out_if      (out_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // predictor state
  logic [15:0] amp_reg;
  logic [4:0]  dims_reg;
  logic [31:0] wt_entry [NDIM];
  logic [31:0] wt_common;
  bit          common_mode;
  logic [47:0] dist_acc;
  logic [4:0]  elem_cnt;

  const int unsigned decay_lut [49] = '{
    65536, 51039, 39750, 30957, 24109, 18776, 14623, 11388,
    8869, 6907, 5380, 4190, 3263, 2541, 1979, 1541,
    1200, 935, 728, 567, 442, 344, 268, 209,
    162, 127, 99, 77, 60, 47, 36, 28,
    22, 17, 13, 10, 8, 6, 5, 4,
    3, 2, 2, 1, 1, 1, 1, 1,
    0
  };

  kres_t  kernel_q [$];
  drow_t  dir_rows [$];
  int     mismatches;
  int     tx_idle_pct;
  int     rx_idle_pct;
  longint unsigned cycles;

  function automatic logic [31:0] ls_to_weight(input logic [15:0] l);
    logic [63:0] sq;
    logic [63:0] w;
    sq = 64'(l) * 64'(l);
    w = ((64'd1 << 31) + sq / 64'd2) / sq;
    if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
    return w[31:0];
  endfunction

  function automatic logic [63:0] decay(input logic [47:0] s);
    logic [63:0] idx;
    logic [63:0] a;
    logic [63:0] b;
    idx = 64'(s >> 14);
    if (idx >= 64'd48) return 64'd0;
    a = 64'(decay_lut[idx]);
    b = 64'(decay_lut[idx + 64'd1]);
    return a - ((((a - b) * 64'(s[13:0])) + 64'd8192) >> 14);
  endfunction

  function automatic void kernel_predict(input word_t w, output bit has, output kres_t r);
    int          d;
    logic [63:0] ad;
    logic [63:0] term;
    logic [31:0] wt;
    logic [63:0] e;
    logic [63:0] k;
    has = 1'b0;
    r = '{kval: 16'd0, st: gre_pkg::ST_OK, fw: 1'b0};
    if (w.op == gre_pkg::OP_SINGLE || w.op == gre_pkg::OP_SHARED) begin
      has = 1'b1;
      r.fw = 1'b1;
      if (w.ls == 16'd0) begin
        r.st = gre_pkg::ST_ZERO_LS;
        return;
      end
      if (w.op == gre_pkg::OP_SHARED) begin
        wt_common = ls_to_weight(w.ls);
        common_mode = 1'b1;
      end else begin
        wt_entry[w.dim] = ls_to_weight(w.ls);
        common_mode = 1'b0;
      end
      return;
    end
    if (w.op != gre_pkg::OP_DATA) return;
    d = int'(w.x) - int'(w.y);
    ad = (d < 0) ? 64'(-d) : 64'(d);
    if (common_mode) wt = wt_common;
    else if (elem_cnt < NDIM) wt = wt_entry[elem_cnt[3:0]];
    else wt = 32'd0;
    term = ((ad * ad) * 64'(wt)) >> 16;
    if (term > 64'(gre_pkg::SUM_MAX - dist_acc)) dist_acc = gre_pkg::SUM_MAX;
    else dist_acc = dist_acc + term[47:0];
    if (elem_cnt < gre_pkg::COUNT_MAX) elem_cnt = elem_cnt + 5'd1;
    if (!w.last) return;
    has = 1'b1;
    if (dims_reg == 5'd0 || dims_reg > NDIM || elem_cnt != dims_reg) begin
      r.st = gre_pkg::ST_MISMATCH;
    end else begin
      e = decay(dist_acc);
      k = (64'(amp_reg) * e + 64'd32768) >> 16;
      r.kval = k[15:0];
    end
    dist_acc = '0;
    elem_cnt = '0;
  endfunction

  function automatic word_t mk_word(input gre_pkg::opcode_e op, input logic [3:0] dim,
                                    input logic [15:0] x, input logic [15:0] y,
                                    input logic [15:0] ls, input logic last);
    word_t w;
    w.op = op;
    w.dim = dim;
    w.x = x;
    w.y = y;
    w.ls = ls;
    w.last = last;
    return w;
  endfunction

  function automatic void add_row(input word_t w, input bit typed, input logic [15:0] kv,
                                  input gre_pkg::status_e st, input logic fw);
    drow_t row;
    row.w = w;
    row.typed = typed;
    row.r = '{kval: kv, st: st, fw: fw};
    dir_rows.push_back(row);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side: sample at the rising edge, move ready at the falling edge
  initial begin
    kres_t exp_r;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) begin
        if (kernel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: kernel_value=%0d status=%0d from_write=%0b",
                     out_bus.kernel_value, out_bus.status, out_bus.from_write);
        end else begin
          exp_r = kernel_q.pop_front();
          if (out_bus.kernel_value !== exp_r.kval || out_bus.status !== exp_r.st ||
              out_bus.from_write !== exp_r.fw) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected kv=%0d st=%0d fw=%0b, got kv=%0d st=%0d fw=%0b",
                       exp_r.kval, exp_r.st, exp_r.fw, out_bus.kernel_value,
                       out_bus.status, out_bus.from_write);
          end
        end
      end
      @(negedge clk_i);
      out_bus.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_word(input word_t w, input bit typed, input kres_t typed_r);
    bit    has;
    kres_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid = 1'b1;
    in_bus.opcode = w.op;
    in_bus.dim_index = w.dim;
    in_bus.x_value = w.x;
    in_bus.y_value = w.y;
    in_bus.lengthscale = w.ls;
    in_bus.last_element = w.last;
    do @(posedge clk_i); while (!in_bus.ready);
    kernel_predict(w, has, r);
    if (has) kernel_q.push_back(typed ? typed_r : r);
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (kernel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input gre_pkg::reg_idx_e idx, input logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = v;
    @(posedge clk_i);
    if (idx == gre_pkg::REG_AMPLITUDE) amp_reg = v;
    else dims_reg = v[4:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [15:0] rand_ls();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 8) return 16'd0;
    if (p < 28) return 16'($urandom);
    return 16'($urandom_range(2048, 64));
  endfunction

  task automatic send_write(inout int sent);
    word_t w;
    kres_t none;
    none = '{kval: 16'd0, st: gre_pkg::ST_OK, fw: 1'b0};
    w = mk_word($urandom_range(1) ? gre_pkg::OP_SHARED : gre_pkg::OP_SINGLE, 4'($urandom),
                16'($urandom), 16'($urandom), rand_ls(), 1'($urandom));
    send_word(w, 1'b0, none);
    sent++;
  endtask

  // one vector of coordinate pairs, mostly of the configured length
  task automatic send_vector(inout int sent);
    int          len;
    int          scale;
    int          delta;
    logic [15:0] xv;
    logic [15:0] yv;
    word_t       w;
    kres_t       none;
    none = '{kval: 16'd0, st: gre_pkg::ST_OK, fw: 1'b0};
    if (dims_reg >= 1 && dims_reg <= NDIM && $urandom_range(99) >= 15) len = int'(dims_reg);
    else if ($urandom_range(9) == 0) len = $urandom_range(34, 30);
    else len = $urandom_range(20, 1);
    scale = $urandom_range(1024, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) send_write(sent);
      xv = 16'($urandom);
      if ($urandom_range(99) < 20) begin
        yv = 16'($urandom);
      end else begin
        delta = int'($urandom_range(2 * scale, 0)) - scale;
        yv = xv + 16'(delta);
      end
      w = mk_word(gre_pkg::OP_DATA, 4'($urandom), xv, yv, 16'($urandom), i == len - 1);
      send_word(w, 1'b0, none);
      sent++;
    end
  endtask

  task automatic run_phase(input logic [15:0] amp, input logic [4:0] dims,
                           input int txp, input int rxp, input int n_words);
    int    sent;
    word_t w;
    kres_t none;
    none = '{kval: 16'd0, st: gre_pkg::ST_OK, fw: 1'b0};
    go_idle();
    write_reg(gre_pkg::REG_AMPLITUDE, amp);
    write_reg(gre_pkg::REG_DIM_COUNT, 16'(dims));
    tx_idle_pct = txp;
    rx_idle_pct = rxp;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(19))
        0: begin
          // ignored opcode, not counted
          w = mk_word(gre_pkg::OP_NONE, 4'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 1'($urandom));
          send_word(w, 1'b0, none);
        end
        1, 2: send_write(sent);
        default: send_vector(sent);
      endcase
    end
  endtask

  initial begin
    mismatches = 0;
    tx_idle_pct = 10;
    rx_idle_pct = 63;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = gre_pkg::REG_AMPLITUDE;
    cfg_data_i = '0;
    in_bus.valid = 1'b0;
    in_bus.opcode = gre_pkg::OP_DATA;
    in_bus.dim_index = '0;
    in_bus.x_value = '0;
    in_bus.y_value = '0;
    in_bus.lengthscale = '0;
    in_bus.last_element = 1'b0;

    amp_reg = gre_pkg::AMP_RESET;
    dims_reg = gre_pkg::DIMC_RESET;
    foreach (wt_entry[i]) wt_entry[i] = '0;
    wt_common = '0;
    common_mode = 1'b1;
    dist_acc = '0;
    elem_cnt = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // shared weight is zero after reset: any pair gives exp(0)
    add_row(mk_word(gre_pkg::OP_DATA, 4'd0, 16'h7FFF, 16'h8000, 16'd0, 1'b1), 1'b1, 16'd256,
            gre_pkg::ST_OK, 1'b0);
    add_row(mk_word(gre_pkg::OP_DATA, 4'd0, 16'h8000, 16'h7FFF, 16'd0, 1'b0), 1'b0, 16'd0,
            gre_pkg::ST_OK, 1'b0);
    add_row(mk_word(gre_pkg::OP_DATA, 4'd0, 16'h0000, 16'h0000, 16'd0, 1'b1), 1'b1, 16'd0,
            gre_pkg::ST_MISMATCH, 1'b0);
    add_row(mk_word(gre_pkg::OP_SHARED, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b1, 16'd0,
            gre_pkg::ST_ZERO_LS, 1'b1);
    add_row(mk_word(gre_pkg::OP_SINGLE, 4'd15, 16'd0, 16'd0, 16'd0, 1'b0), 1'b1, 16'd0,
            gre_pkg::ST_ZERO_LS, 1'b1);
    add_row(mk_word(gre_pkg::OP_NONE, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1), 1'b0, 16'd0,
            gre_pkg::ST_OK, 1'b0);
    add_row(mk_word(gre_pkg::OP_SHARED, 4'd0, 16'd0, 16'd0, 16'd1, 1'b0), 1'b1, 16'd0,
            gre_pkg::ST_OK, 1'b1);
    add_row(mk_word(gre_pkg::OP_DATA, 4'd0, 16'h7FFF, 16'h8000, 16'd0, 1'b1), 1'b1, 16'd0,
            gre_pkg::ST_OK, 1'b0);
    add_row(mk_word(gre_pkg::OP_SHARED, 4'd0, 16'd0, 16'd0, 16'hFFFF, 1'b0), 1'b1, 16'd0,
            gre_pkg::ST_OK, 1'b1);
    add_row(mk_word(gre_pkg::OP_DATA, 4'd0, 16'h0100, 16'hFF00, 16'd0, 1'b1), 1'b0, 16'd0,
            gre_pkg::ST_OK, 1'b0);
    // fill every table entry; the first of these writes leaves shared mode
    for (int i = 0; i < NDIM; i++)
      add_row(mk_word(gre_pkg::OP_SINGLE, 4'(i), 16'd0, 16'd0, 16'(256 + 97 * i), 1'b0),
              1'b1, 16'd0, gre_pkg::ST_OK, 1'b1);
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);

    run_phase(16'hFFFF, 5'd16, 10, 63, 230);
    run_phase(16'h0000, 5'd1, 10, 63, 230);
    run_phase(16'($urandom), 5'($urandom_range(16, 1)), 63, 10, 230);
    run_phase(16'($urandom), 5'd31, 63, 10, 120);
    run_phase(16'd256, 5'd0, 0, 0, 120);
    run_phase(16'($urandom), 5'($urandom_range(16, 1)), 0, 0, 230);
    run_phase(16'($urandom), 5'd4, 0, 0, 230);

    go_idle();
    if (mismatches == 0 && kernel_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* gaussian_rbf_kernel_eval.f */
+incdir+src
src/gre_pkg.sv
src/gre_in_if.sv
src/gre_out_if.sv
src/gre_wdiv.sv
src/gre_wmem.sv
src/gaussian_rbf_kernel_eval.sv
tb/gaussian_rbf_kernel_eval_tb.sv
